// ===== hw/rtl/mvh_pkg.sv =====
// Shared types and constants for the MPEG-4 VOP header scanner.
// No dependencies; imported by mvh_bit_engine and mpeg4_vop_header_scanner.
`default_nettype none

package mvh_pkg;

    localparam int STREAM_BYTES = 1048576;
    localparam int IDX_W        = $clog2(STREAM_BYTES);
    localparam int OFFSET_W     = 23;
    localparam int TRES_W       = 16;
    localparam int TINC_W       = 5;

    localparam logic [IDX_W:0]    STREAM_BYTES_W = (IDX_W + 1)'(STREAM_BYTES);
    localparam logic [7:0]        BYTE_ZERO      = 8'h00;
    localparam logic [7:0]        BYTE_ONE       = 8'h01;
    localparam logic [7:0]        VOP_CODE       = 8'hB6;
    localparam logic [TRES_W-1:0] TRES_RESET     = 16'd30;
    localparam logic [4:0]        DCTHR_BITS     = 5'd3;
    localparam logic [4:0]        QUANT_BITS     = 5'd5;
    localparam logic [4:0]        FCODE_BITS     = 5'd3;
    localparam logic [4:0]        TYPE_BITS      = 5'd2;

    localparam logic [1:0] TYPE_I = 2'd0;
    localparam logic [1:0] TYPE_P = 2'd1;
    localparam logic [1:0] TYPE_B = 2'd2;

    typedef enum logic [3:0] {
        PH_SCAN  = 4'd0,
        PH_CODE  = 4'd1,
        PH_TYPE  = 4'd2,
        PH_MTB   = 4'd3,
        PH_MARK1 = 4'd4,
        PH_TINC  = 4'd5,
        PH_MARK2 = 4'd6,
        PH_CODED = 4'd7,
        PH_ROUND = 4'd8,
        PH_DCTHR = 4'd9,
        PH_QUANT = 4'd10,
        PH_FCF   = 4'd11,
        PH_FCB   = 4'd12
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [1:0]       zero_run;
        logic [IDX_W-1:0] byte_index;
        logic [4:0]       field_left;
        logic [4:0]       field_shift;
        logic [1:0]       held_type;
        logic [2:0]       held_threshold;
        logic [4:0]       held_quant;
        logic             held_marker_error;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]          coding_type;
        logic [2:0]          dc_vlc_threshold;
        logic [4:0]          quantizer;
        logic [OFFSET_W-1:0] data_bit_offset;
        logic                marker_error;
    } header_t;

    // Bit length of the time resolution, 0..16
    function automatic logic [TINC_W-1:0] bit_length(input logic [TRES_W-1:0] value);
        logic [TINC_W-1:0] w;
        w = '0;
        for (int i = 0; i < TRES_W; i++) begin
            if (value[i]) begin
                w = TINC_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mvh_bit_engine.sv =====
// Per-byte next-state logic: start code scan and MSB-first header bit parse.
// Depends on mvh_pkg; purely combinational, instantiated by the top level.
`default_nettype none

module mvh_bit_engine
    import mvh_pkg::*;
(
    input  wire parse_state_t      state,
    input  wire logic [7:0]        stream_byte,
    input  wire logic              last_byte,
    input  wire logic [TINC_W-1:0] tinc_width,
    output parse_state_t           state_next,
    output logic                   result_valid,
    output header_t                result
);

    parse_state_t          st;
    logic                  ended;
    logic                  tail;
    logic                  stop;
    logic                  hit;
    logic                  b;
    logic [4:0]            shifted;
    logic                  fdone;
    logic [4:0]            fleft;
    logic [OFFSET_W-1:0]   base;
    logic [IDX_W:0]        idx_inc;

    always_comb
    begin
        st           = state;
        ended        = 1'b0;
        tail         = 1'b0;
        stop         = 1'b0;
        hit          = 1'b0;
        b            = 1'b0;
        shifted      = '0;
        fdone        = 1'b0;
        fleft        = '0;
        result_valid = 1'b0;
        result       = '0;
        base         = OFFSET_W'({state.byte_index, 3'b000});

        if (state.phase == PH_SCAN) begin
            if (stream_byte == BYTE_ZERO) begin
                if (st.zero_run < 2'd2) begin
                    st.zero_run = st.zero_run + 2'd1;
                end
            end else if (stream_byte == BYTE_ONE && st.zero_run >= 2'd2) begin
                st.phase    = PH_CODE;
                st.zero_run = '0;
            end else begin
                st.zero_run = '0;
            end
        end else if (state.phase == PH_CODE) begin
            if (stream_byte == VOP_CODE) begin
                st.phase             = PH_TYPE;
                st.field_left        = TYPE_BITS;
                st.field_shift       = '0;
                st.held_type         = '0;
                st.held_threshold    = '0;
                st.held_quant        = '0;
                st.held_marker_error = 1'b0;
            end else begin
                st.phase = PH_SCAN;
            end
            st.zero_run = '0;
        end else begin
            for (int k = 0; k < 8; k++) begin
                if (!ended) begin
                    stop    = 1'b0;
                    hit     = 1'b0;
                    b       = stream_byte[3'(7 - k)];
                    shifted = {st.field_shift[3:0], b};
                    fdone   = (st.field_left <= 5'd1);
                    fleft   = fdone ? 5'd0 : st.field_left - 5'd1;
                    case (st.phase)
                        PH_TYPE:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                st.held_type = shifted[1:0];
                                st.phase     = PH_MTB;
                            end
                        end
                        PH_MTB:
                        begin
                            if (!b) begin
                                st.phase = PH_MARK1;
                            end
                        end
                        PH_MARK1:
                        begin
                            if (!b) begin
                                st.held_marker_error = 1'b1;
                            end
                            if (tinc_width != '0) begin
                                st.phase       = PH_TINC;
                                st.field_left  = 5'(tinc_width);
                                st.field_shift = '0;
                            end else begin
                                st.phase = PH_MARK2;
                            end
                        end
                        PH_TINC:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                st.phase = PH_MARK2;
                            end
                        end
                        PH_MARK2:
                        begin
                            if (!b) begin
                                st.held_marker_error = 1'b1;
                            end
                            st.phase = PH_CODED;
                        end
                        PH_CODED:
                        begin
                            // uncoded VOP: end the header with no item
                            if (!b) begin
                                stop = 1'b1;
                            end else if (st.held_type == TYPE_P) begin
                                st.phase = PH_ROUND;
                            end else begin
                                st.phase       = PH_DCTHR;
                                st.field_left  = DCTHR_BITS;
                                st.field_shift = '0;
                            end
                        end
                        PH_ROUND:
                        begin
                            st.phase       = PH_DCTHR;
                            st.field_left  = DCTHR_BITS;
                            st.field_shift = '0;
                        end
                        PH_DCTHR:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                st.held_threshold = shifted[2:0];
                                st.phase          = PH_QUANT;
                                st.field_left     = QUANT_BITS;
                                st.field_shift    = '0;
                            end
                        end
                        PH_QUANT:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                st.held_quant = shifted;
                                if (st.held_type == TYPE_I) begin
                                    stop = 1'b1;
                                    hit  = 1'b1;
                                end else begin
                                    st.phase       = PH_FCF;
                                    st.field_left  = FCODE_BITS;
                                    st.field_shift = '0;
                                end
                            end
                        end
                        PH_FCF:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                if (st.held_type == TYPE_B) begin
                                    st.phase       = PH_FCB;
                                    st.field_left  = FCODE_BITS;
                                    st.field_shift = '0;
                                end else begin
                                    stop = 1'b1;
                                    hit  = 1'b1;
                                end
                            end
                        end
                        PH_FCB:
                        begin
                            st.field_shift = shifted;
                            st.field_left  = fleft;
                            if (fdone) begin
                                stop = 1'b1;
                                hit  = 1'b1;
                            end
                        end
                        default:
                        begin
                            stop = 1'b1;
                        end
                    endcase
                    if (stop) begin
                        ended        = 1'b1;
                        tail         = (k < 7);
                        result_valid = hit;
                        result.coding_type      = st.held_type;
                        result.dc_vlc_threshold = st.held_threshold;
                        result.quantizer        = st.held_quant;
                        result.marker_error     = st.held_marker_error;
                        result.data_bit_offset  = base + OFFSET_W'(k + 1);
                    end
                end
            end
            if (ended) begin
                // rescan the rest of the byte with a cleared zero count
                st.phase    = PH_SCAN;
                st.zero_run = (tail && stream_byte == BYTE_ZERO) ? 2'd1 : 2'd0;
            end
        end

        idx_inc = {1'b0, state.byte_index} + 1'b1;
        if (idx_inc >= STREAM_BYTES_W) begin
            st.byte_index = '0;
        end else begin
            st.byte_index = idx_inc[IDX_W-1:0];
        end

        if (last_byte) begin
            st = '0;
        end
        state_next = st;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mpeg4_vop_header_scanner.sv =====
// A header item enters main (or skid, while main is held) when the stream item
// holding its last bit is accepted. Throughput: one stream byte per cycle while
// stream_stall is low. A two-entry output register (main plus skid) keeps the
// input open while one result waits; stream_stall rises only when both entries
// are full. Reset (rst_n low, async) returns the parser to start-code scanning,
// clears the byte count and both output entries, and sizes tinc for resolution 30.
`default_nettype none

module mpeg4_vop_header_scanner
    import mvh_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                time_resolution_we,
    input  wire logic [TRES_W-1:0]   time_resolution,
    input  wire logic                stream_valid,
    output logic                     stream_stall,
    input  wire logic [7:0]          stream_byte,
    input  wire logic                last_byte,
    output logic                     header_valid,
    input  wire logic                header_stall,
    output logic [1:0]               coding_type,
    output logic [2:0]               dc_vlc_threshold,
    output logic [4:0]               quantizer,
    output logic [OFFSET_W-1:0]      data_bit_offset,
    output logic                     marker_error
);

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [TINC_W-1:0] tinc_width_reg;
    logic              res_valid;
    header_t           res;

    logic              main_valid_reg;
    header_t           main_reg;
    logic              skid_valid_reg;
    header_t           skid_reg;

    logic              accept;
    logic              take;

    mvh_bit_engine u_engine (
        .state        (state_reg),
        .stream_byte  (stream_byte),
        .last_byte    (last_byte),
        .tinc_width   (tinc_width_reg),
        .state_next   (state_next),
        .result_valid (res_valid),
        .result       (res)
    );

    assign stream_stall = skid_valid_reg;
    assign accept       = stream_valid && !skid_valid_reg;
    assign take         = main_valid_reg && !header_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= '0;
            tinc_width_reg <= bit_length(TRES_RESET);
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (time_resolution_we) begin
                tinc_width_reg <= bit_length(time_resolution);
            end
        end
    end

    // main entry drains first; skid only fills while main is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept && res_valid) begin
                if (!main_valid_reg || take) begin
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (take) begin
                main_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid) begin
            if (!main_valid_reg || take) begin
                main_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end else if (take && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

    assign header_valid     = main_valid_reg;
    assign coding_type      = main_reg.coding_type;
    assign dc_vlc_threshold = main_reg.dc_vlc_threshold;
    assign quantizer        = main_reg.quantizer;
    assign data_bit_offset  = main_reg.data_bit_offset;
    assign marker_error     = main_reg.marker_error;

endmodule

`default_nettype wire

// ===== tb/mpeg4_vop_header_scanner_test.sv =====
// Self-checking bench for mpeg4_vop_header_scanner: random byte streams with VOP headers,
// an in-bench parser that predicts every header item, field-by-field result compare.
// Depends on mvh_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module mpeg4_vop_header_scanner_test
    import mvh_pkg::*;
();

    localparam logic [1:0] KIND_S          = 2'd3;
    localparam int         WATCHDOG_CYCLES = 1000;
    localparam int         SETTLE_CYCLES   = 8;

    typedef enum int {HDR_OPEN, HDR_QUIET, HDR_DONE} hdr_verdict_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } feed_item_t;

    typedef struct {
        int          zeros;
        logic [7:0]  code;
        logic [1:0]  kind;
        int          ones;
        logic        mark1;
        logic        mark2;
        logic        coded;
        logic        rounding;
        logic [15:0] tinc;
        logic [2:0]  thr;
        logic [4:0]  quant;
        logic [2:0]  fwd;
        logic [2:0]  bwd;
        int          pad;
        int          cut;
    } vop_plan_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                time_resolution_we = 1'b0;
    logic [TRES_W-1:0]   time_resolution = TRES_RESET;
    logic                stream_valid = 1'b0;
    logic                stream_stall;
    logic [7:0]          stream_byte = 8'h00;
    logic                last_byte = 1'b0;
    logic                header_valid;
    logic                header_stall = 1'b0;
    logic [1:0]          coding_type;
    logic [2:0]          dc_vlc_threshold;
    logic [4:0]          quantizer;
    logic [OFFSET_W-1:0] data_bit_offset;
    logic                marker_error;

    mpeg4_vop_header_scanner dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .time_resolution_we (time_resolution_we),
        .time_resolution    (time_resolution),
        .stream_valid       (stream_valid),
        .stream_stall       (stream_stall),
        .stream_byte        (stream_byte),
        .last_byte          (last_byte),
        .header_valid       (header_valid),
        .header_stall       (header_stall),
        .coding_type        (coding_type),
        .dc_vlc_threshold   (dc_vlc_threshold),
        .quantizer          (quantizer),
        .data_bit_offset    (data_bit_offset),
        .marker_error       (marker_error)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    feed_item_t  byte_feed[$];
    header_t     expected_headers[$];
    feed_item_t  next_item;

    // parser copy used for prediction
    phase_t      vop_phase;
    logic [1:0]  zero_count;
    int          byte_pos;
    int          field_left;
    logic [7:0]  field_acc;
    logic [1:0]  vop_type;
    logic [2:0]  vop_thr;
    logic [4:0]  vop_qp;
    logic        vop_merr;
    logic [15:0] tres_now;

    logic        byte_taken = 1'b0;
    logic        hdr_taken = 1'b0;
    int          send_hold = 0;
    int          stall_hold = 0;
    int          send_calm = 0;
    int          recv_calm = 0;
    int          quiet_cycles = 0;

    logic [15:0] tres_setting = TRES_RESET;
    int          total_fed = 0;
    int          bytes_taken = 0;
    int          headers_seen = 0;
    int          marker_flags = 0;
    int          settings_used = 0;
    int          mismatches = 0;

    function automatic int tinc_bits(logic [15:0] res);
        int          w;
        logic [15:0] r;
        w = 0;
        r = res;
        while (r != 0)
        begin
            w++;
            r = r >> 1;
        end
        return w;
    endfunction

    function automatic void parser_clear();
        vop_phase = PH_SCAN;
        zero_count = '0;
        byte_pos = 0;
        field_left = 0;
        field_acc = '0;
        vop_type = '0;
        vop_thr = '0;
        vop_qp = '0;
        vop_merr = 1'b0;
    endfunction

    function automatic void open_field(phase_t ph, int n);
        vop_phase = ph;
        field_left = n;
        field_acc = '0;
    endfunction

    function automatic bit take_field_bit(logic b);
        field_acc = {field_acc[6:0], b};
        if (field_left <= 1)
        begin
            field_left = 0;
            return 1'b1;
        end
        field_left--;
        return 1'b0;
    endfunction

    function automatic void scan_for_start(logic [7:0] b);
        if (b == BYTE_ZERO)
        begin
            if (zero_count < 2)
                zero_count++;
        end
        else if (b == BYTE_ONE && zero_count >= 2)
        begin
            vop_phase = PH_CODE;
            zero_count = '0;
        end
        else
            zero_count = '0;
    endfunction

    function automatic hdr_verdict_t header_bit(logic b);
        int w;
        case (vop_phase)
            PH_TYPE:
                if (take_field_bit(b))
                begin
                    vop_type = field_acc[1:0];
                    vop_phase = PH_MTB;
                end
            PH_MTB:
                if (!b)
                    vop_phase = PH_MARK1;
            PH_MARK1:
            begin
                if (!b)
                    vop_merr = 1'b1;
                w = tinc_bits(tres_now);
                if (w > 0)
                    open_field(PH_TINC, w);
                else
                    vop_phase = PH_MARK2;
            end
            PH_TINC:
                if (take_field_bit(b))
                    vop_phase = PH_MARK2;
            PH_MARK2:
            begin
                if (!b)
                    vop_merr = 1'b1;
                vop_phase = PH_CODED;
            end
            PH_CODED:
            begin
                if (!b)
                    return HDR_QUIET;
                if (vop_type == TYPE_P)
                    vop_phase = PH_ROUND;
                else
                    open_field(PH_DCTHR, DCTHR_BITS);
            end
            PH_ROUND:
                open_field(PH_DCTHR, DCTHR_BITS);
            PH_DCTHR:
                if (take_field_bit(b))
                begin
                    vop_thr = field_acc[2:0];
                    open_field(PH_QUANT, QUANT_BITS);
                end
            PH_QUANT:
                if (take_field_bit(b))
                begin
                    vop_qp = field_acc[4:0];
                    if (vop_type == TYPE_I)
                        return HDR_DONE;
                    open_field(PH_FCF, FCODE_BITS);
                end
            PH_FCF:
                if (take_field_bit(b))
                begin
                    if (vop_type == TYPE_B)
                        open_field(PH_FCB, FCODE_BITS);
                    else
                        return HDR_DONE;
                end
            PH_FCB:
                if (take_field_bit(b))
                    return HDR_DONE;
            default:
                return HDR_QUIET;
        endcase
        return HDR_OPEN;
    endfunction

    function automatic void absorb_byte(logic [7:0] b, logic last);
        hdr_verdict_t v;
        header_t      h;
        if (vop_phase == PH_SCAN)
            scan_for_start(b);
        else if (vop_phase == PH_CODE)
        begin
            if (b == VOP_CODE)
            begin
                open_field(PH_TYPE, TYPE_BITS);
                vop_type = '0;
                vop_thr = '0;
                vop_qp = '0;
                vop_merr = 1'b0;
            end
            else
                vop_phase = PH_SCAN;
            zero_count = '0;
        end
        else
        begin
            for (int i = 7; i >= 0; i--)
            begin
                v = header_bit(b[i]);
                if (v != HDR_OPEN)
                begin
                    vop_phase = PH_SCAN;
                    zero_count = '0;
                    if (v == HDR_DONE)
                    begin
                        h.coding_type = vop_type;
                        h.dc_vlc_threshold = vop_thr;
                        h.quantizer = vop_qp;
                        h.data_bit_offset = OFFSET_W'(byte_pos * 8 + 8 - i);
                        h.marker_error = vop_merr;
                        expected_headers.push_back(h);
                    end
                    // rescan the rest of this byte as a start-code candidate
                    if (i > 0)
                        scan_for_start(b);
                    break;
                end
            end
        end
        byte_pos = (byte_pos + 1 >= STREAM_BYTES) ? 0 : byte_pos + 1;
        if (last)
            parser_clear();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d (header item %0d, t=%0t)",
                 what, got, want, headers_seen, $time);
    endtask

    task automatic check_header();
        header_t want;
        headers_seen++;
        if (expected_headers.size() == 0)
        begin
            report_mismatch("header item with none expected", data_bit_offset, 0);
            return;
        end
        want = expected_headers.pop_front();
        if (marker_error)
            marker_flags++;
        if (coding_type !== want.coding_type)
            report_mismatch("coding_type", coding_type, want.coding_type);
        if (dc_vlc_threshold !== want.dc_vlc_threshold)
            report_mismatch("dc_vlc_threshold", dc_vlc_threshold, want.dc_vlc_threshold);
        if (quantizer !== want.quantizer)
            report_mismatch("quantizer", quantizer, want.quantizer);
        if (data_bit_offset !== want.data_bit_offset)
            report_mismatch("data_bit_offset", data_bit_offset, want.data_bit_offset);
        if (marker_error !== want.marker_error)
            report_mismatch("marker_error", marker_error, want.marker_error);
    endtask

    // monitor: check results, then advance the predictor on the accepted item
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            parser_clear();
            tres_now = TRES_RESET;
            byte_taken <= 1'b0;
            hdr_taken <= 1'b0;
        end
        else
        begin
            byte_taken <= stream_valid && !stream_stall;
            hdr_taken <= header_valid && !header_stall;
            if (header_valid && !header_stall)
                check_header();
            if (stream_valid && !stream_stall)
            begin
                absorb_byte(stream_byte, last_byte);
                bytes_taken++;
            end
            if (time_resolution_we)
                tres_now = time_resolution;
        end
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(16, 64);
        return $urandom_range(0, 4);
    endfunction

    // stream driver
    always @(negedge clk)
    begin
        if (rst_n && (!stream_valid || byte_taken))
        begin
            if (send_hold > 0)
            begin
                stream_valid <= 1'b0;
                send_hold--;
            end
            else if (byte_feed.size() > 0)
            begin
                next_item = byte_feed.pop_front();
                stream_valid <= 1'b1;
                stream_byte <= next_item.value;
                last_byte <= next_item.last;
                send_hold = draw_wait(send_calm);
            end
            else
                stream_valid <= 1'b0;
        end
    end

    // result receiver: hold stall for a random wait drawn after each taken item
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_taken)
                stall_hold = draw_wait(recv_calm);
            if (stall_hold > 0)
            begin
                header_stall <= 1'b1;
                stall_hold--;
            end
            else
                header_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((stream_valid && !stream_stall) || (header_valid && !header_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Timeout: no item moved for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic feed_byte(logic [7:0] b, logic last);
        byte_feed.push_back({b, last});
        total_fed++;
    endtask

    function automatic vop_plan_t random_plan();
        vop_plan_t p;
        p.zeros = ($urandom_range(0, 9) < 7) ? 2 : $urandom_range(1, 5);
        p.code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : VOP_CODE;
        p.kind = 2'($urandom);
        p.ones = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        p.mark1 = ($urandom_range(0, 9) != 0);
        p.mark2 = ($urandom_range(0, 9) != 0);
        p.coded = ($urandom_range(0, 7) != 0);
        p.rounding = 1'($urandom);
        p.tinc = 16'($urandom);
        p.thr = 3'($urandom);
        p.quant = 5'($urandom);
        p.fwd = 3'($urandom);
        p.bwd = 3'($urandom);
        p.pad = $urandom_range(0, 2);
        p.cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4) : 0;
        return p;
    endfunction

    function automatic vop_plan_t plain_plan(logic [1:0] kind);
        vop_plan_t p;
        p = random_plan();
        p.zeros = 2;
        p.code = VOP_CODE;
        p.kind = kind;
        p.ones = 0;
        p.mark1 = 1'b1;
        p.mark2 = 1'b1;
        p.coded = 1'b1;
        p.cut = 0;
        return p;
    endfunction

    // start code, code byte, then (for a VOP code) header bits packed MSB first and padded to a byte
    task automatic send_vop(vop_plan_t p);
        bit         hb[$];
        int         w;
        int         nbytes;
        logic [7:0] acc;
        w = tinc_bits(tres_setting);
        repeat (p.zeros) feed_byte(BYTE_ZERO, 1'b0);
        feed_byte(BYTE_ONE, 1'b0);
        feed_byte(p.code, 1'b0);
        if (p.code != VOP_CODE)
            return;
        hb.push_back(p.kind[1]);
        hb.push_back(p.kind[0]);
        repeat (p.ones) hb.push_back(1'b1);
        hb.push_back(1'b0);
        hb.push_back(p.mark1);
        for (int i = w - 1; i >= 0; i--)
            hb.push_back(p.tinc[i]);
        hb.push_back(p.mark2);
        hb.push_back(p.coded);
        if (p.coded)
        begin
            if (p.kind == TYPE_P)
                hb.push_back(p.rounding);
            for (int i = 2; i >= 0; i--)
                hb.push_back(p.thr[i]);
            for (int i = 4; i >= 0; i--)
                hb.push_back(p.quant[i]);
            if (p.kind != TYPE_I)
                for (int i = 2; i >= 0; i--)
                    hb.push_back(p.fwd[i]);
            if (p.kind == TYPE_B)
                for (int i = 2; i >= 0; i--)
                    hb.push_back(p.bwd[i]);
        end
        while (hb.size() % 8 != 0)
            hb.push_back((p.pad == 0) ? 1'($urandom) : (p.pad == 2));
        nbytes = hb.size() / 8;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int j = 0; j < 8; j++)
                acc[7 - j] = hb[k * 8 + j];
            feed_byte(acc, p.cut == k + 1);
            // truncate: end the buffer inside the header
            if (p.cut == k + 1)
                return;
        end
    endtask

    task automatic send_noise(int n);
        int roll;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                feed_byte(BYTE_ZERO, $urandom_range(0, 39) == 0);
            else if (roll < 55)
                feed_byte(BYTE_ONE, $urandom_range(0, 39) == 0);
            else if (roll < 65)
                feed_byte(VOP_CODE, 1'b0);
            else
                feed_byte(8'($urandom), $urandom_range(0, 39) == 0);
        end
    endtask

    task automatic random_traffic(int budget);
        int first;
        int roll;
        first = total_fed;
        while (total_fed - first < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                send_vop(random_plan());
            else if (roll < 95)
                send_noise($urandom_range(1, 8));
            else
                feed_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (byte_feed.size() != 0 || stream_valid || expected_headers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_time_resolution(logic [15:0] v);
        drain();
        @(negedge clk);
        time_resolution <= v;
        time_resolution_we <= 1'b1;
        @(negedge clk);
        time_resolution_we <= 1'b0;
        tres_setting = v;
        settings_used++;
    endtask

    initial
    begin
        vop_plan_t   p;
        logic [15:0] res_plan [6];

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the register first, with the directed headers
        p = plain_plan(TYPE_I); p.thr = 3'd7; p.quant = 5'd31; p.tinc = 16'hFFFF;
        send_vop(p);
        p = plain_plan(TYPE_I); p.thr = 3'd0; p.quant = 5'd0; p.tinc = 16'h0000; p.pad = 1;
        send_vop(p);
        p = plain_plan(TYPE_P); p.rounding = 1'b1; p.fwd = 3'd7;
        send_vop(p);
        p = plain_plan(TYPE_B); p.fwd = 3'd0; p.bwd = 3'd7; p.pad = 2;
        send_vop(p);
        send_vop(plain_plan(KIND_S));
        p = plain_plan(TYPE_P); p.ones = 3; p.mark1 = 1'b0;
        send_vop(p);
        p = plain_plan(TYPE_B); p.mark2 = 1'b0;
        send_vop(p);
        p = plain_plan(TYPE_P); p.coded = 1'b0;
        send_vop(p);
        p = plain_plan(TYPE_I); p.code = VOP_CODE + 8'd1;
        send_vop(p);
        p = plain_plan(TYPE_I); p.zeros = 4;
        send_vop(p);
        p = plain_plan(TYPE_B); p.cut = 1;
        send_vop(p);
        feed_byte(BYTE_ZERO, 1'b0);
        p = plain_plan(TYPE_I); p.zeros = 1;
        send_vop(p);
        random_traffic(200);
        feed_byte(8'($urandom), 1'b1);

        res_plan[0] = 16'd1;
        res_plan[1] = 16'hFFFF;
        res_plan[2] = 16'd0;
        res_plan[3] = 16'h8000;
        res_plan[4] = 16'($urandom_range(2, 65534));
        res_plan[5] = 16'($urandom_range(2, 255));
        for (int s = 0; s < 6; s++)
        begin
            load_time_resolution(res_plan[s]);
            p = plain_plan(TYPE_I); p.tinc = 16'hFFFF;
            send_vop(p);
            send_vop(plain_plan(TYPE_B));
            random_traffic(140);
            feed_byte(8'($urandom), 1'b1);
        end
        drain();

        $display("Covered %0d stream bytes and %0d header items (%0d with marker errors)",
                 bytes_taken, headers_seen, marker_flags);
        $display("over %0d time_resolution writes, with random stalls on both sides",
                 settings_used);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
